// ----- hdl/irpcr_pkg.sv -----
// irpcr_pkg: shared constants, request codes and the controller command struct
// for the ir pulse capture/replay block. Used by every module of the block.
// No dependencies.
`timescale 1ns / 1ps

package irpcr_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam int PERIOD_W    = 16;
	localparam int DUR_W       = 32;
	localparam int THR_W       = 32;
	localparam int KIND_W      = 2;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 24;

	localparam logic [KIND_W-1:0] REQ_CAPTURE = 2'd0;
	localparam logic [KIND_W-1:0] REQ_START   = 2'd1;
	localparam logic [KIND_W-1:0] REQ_EXPIRY  = 2'd2;
	localparam logic [KIND_W-1:0] REQ_CLEAR   = 2'd3;

	localparam logic [THR_W-1:0] GAP_THRESHOLD_RST = 32'd65535;

	typedef struct packed {
		logic accept;
		logic exec;
	} cmd_t;

endpackage

// ----- hdl/irpcr_ctrl.sv -----
// irpcr_ctrl: request sequencer and result handshake for the capture/replay block.
// Issues the accept and execute commands to the datapath. Depends on irpcr_pkg.
`timescale 1ns / 1ps

module irpcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output irpcr_pkg::cmd_t   cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_vld_q;

	// a finished result may still wait as long as it is taken in the cycle we accept
	assign s_tready   = (state_q == ST_IDLE) && (!out_vld_q || m_tready);
	assign cmd.accept = s_tvalid && s_tready;
	assign cmd.exec   = (state_q == ST_EXEC);
	assign m_tvalid   = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/irpcr_datapath.sv -----
// irpcr_datapath: pulse store, replay/capture state and result register.
// Driven by the commands of irpcr_ctrl. Depends on irpcr_pkg.
`timescale 1ns / 1ps

module irpcr_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  irpcr_pkg::cmd_t                      cmd,
	input  logic [irpcr_pkg::KIND_W-1:0]         req_type,
	input  logic [irpcr_pkg::DUR_W-1:0]          duration,
	input  logic                                 cfg_we,
	input  logic [irpcr_pkg::THR_W-1:0]          cfg_wdata,
	output logic [irpcr_pkg::OUT_DATA_W-1:0]     result
);

	localparam logic [irpcr_pkg::CNT_W-1:0] DEPTH_C =
		irpcr_pkg::CNT_W'(irpcr_pkg::STORE_DEPTH);
	localparam logic [irpcr_pkg::CNT_W-1:0] ONE_C = irpcr_pkg::CNT_W'(1);
	localparam logic [irpcr_pkg::CNT_W-1:0] TWO_C = irpcr_pkg::CNT_W'(2);

	logic [irpcr_pkg::PERIOD_W-1:0] mem [irpcr_pkg::STORE_DEPTH];
	logic [irpcr_pkg::STORE_DEPTH-1:0] vld_q;

	logic [irpcr_pkg::THR_W-1:0]    gap_thr_q;
	logic [irpcr_pkg::CNT_W-1:0]    wr_cnt_q;
	logic [irpcr_pkg::CNT_W-1:0]    rp_idx_q;
	logic                           replaying_q;
	logic                           carrier_q;
	logic                           ovf_q;

	// item registers, captured at accept; the result register is loaded at execute
	logic [irpcr_pkg::KIND_W-1:0]   kind_q;
	logic [irpcr_pkg::PERIOD_W-1:0] dur_q;
	logic                           gap_hit_q;
	logic [irpcr_pkg::PERIOD_W-1:0] rd_data_q;
	logic                           rd_vld_q;
	logic [irpcr_pkg::OUT_DATA_W-1:0] result_q;

	logic [irpcr_pkg::ADDR_W-1:0]   rd_addr;
	logic                           rd_oob;

	// next-state values for the execute cycle
	logic [irpcr_pkg::PERIOD_W-1:0] entry;
	logic [irpcr_pkg::CNT_W-1:0]    cap_idx;
	logic [irpcr_pkg::CNT_W-1:0]    cap_nxt;
	logic                           cap_wr;
	logic                           term_clr;
	logic [irpcr_pkg::CNT_W-1:0]    wr_cnt_d;
	logic [irpcr_pkg::CNT_W-1:0]    rp_idx_d;
	logic                           replaying_d;
	logic                           carrier_d;
	logic                           ovf_d;
	logic                           load_d;
	logic [irpcr_pkg::PERIOD_W-1:0] period_d;

	always_comb begin
		if (req_type == irpcr_pkg::REQ_START) begin
			rd_addr = irpcr_pkg::ADDR_W'(1);
			rd_oob  = 1'b0;
		end else begin
			rd_addr = rp_idx_q[irpcr_pkg::ADDR_W-1:0];
			rd_oob  = (rp_idx_q >= DEPTH_C);
		end
	end

	assign entry = rd_vld_q ? rd_data_q : '0;

	always_comb begin
		cap_idx     = gap_hit_q ? '0 : wr_cnt_q;
		cap_nxt     = cap_idx + ONE_C;
		cap_wr      = 1'b0;
		term_clr    = 1'b0;
		wr_cnt_d    = wr_cnt_q;
		rp_idx_d    = rp_idx_q;
		replaying_d = replaying_q;
		carrier_d   = carrier_q;
		ovf_d       = ovf_q;
		load_d      = 1'b0;
		period_d    = '0;
		unique case (kind_q)
			irpcr_pkg::REQ_CAPTURE: begin
				if (!replaying_q && !ovf_q) begin
					if (cap_idx < DEPTH_C) begin
						cap_wr   = 1'b1;
						term_clr = (cap_nxt < DEPTH_C);
						wr_cnt_d = cap_nxt;
					end else begin
						ovf_d = 1'b1;
					end
				end
			end
			irpcr_pkg::REQ_START: begin
				rp_idx_d = ONE_C;
				if (entry != '0) begin
					replaying_d = 1'b1;
					carrier_d   = 1'b1;
					load_d      = 1'b1;
					period_d    = entry;
					rp_idx_d    = TWO_C;
				end else begin
					replaying_d = 1'b0;
					carrier_d   = 1'b0;
				end
			end
			irpcr_pkg::REQ_EXPIRY: begin
				// entry is already zero when the index ran past the store
				if (replaying_q && entry != '0) begin
					carrier_d = !carrier_q;
					load_d    = 1'b1;
					period_d  = entry;
					rp_idx_d  = rp_idx_q + ONE_C;
				end else begin
					carrier_d   = 1'b0;
					replaying_d = 1'b0;
				end
			end
			irpcr_pkg::REQ_CLEAR: begin
				ovf_d = 1'b0;
			end
			default: begin
				ovf_d = ovf_q;
			end
		endcase
	end

	// store: one write port, registered read; entries without a valid bit read as zero
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.exec && cap_wr) begin
			mem[cap_idx[irpcr_pkg::ADDR_W-1:0]] <= dur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.exec) begin
			if (cap_wr) begin
				vld_q[cap_idx[irpcr_pkg::ADDR_W-1:0]] <= 1'b1;
			end
			// terminator: clearing the valid bit makes the entry read as zero
			if (term_clr) begin
				vld_q[cap_nxt[irpcr_pkg::ADDR_W-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_thr_q   <= irpcr_pkg::GAP_THRESHOLD_RST;
			wr_cnt_q    <= '0;
			rp_idx_q    <= '0;
			replaying_q <= 1'b0;
			carrier_q   <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				gap_thr_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				wr_cnt_q    <= wr_cnt_d;
				rp_idx_q    <= rp_idx_d;
				replaying_q <= replaying_d;
				carrier_q   <= carrier_d;
				ovf_q       <= ovf_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q    <= req_type;
			dur_q     <= duration[irpcr_pkg::PERIOD_W-1:0];
			gap_hit_q <= (duration > gap_thr_q);
			rd_vld_q  <= vld_q[rd_addr] && !rd_oob;
		end
		if (cmd.exec) begin
			result_q <= {4'b0000, ovf_d, replaying_d, period_d, load_d, carrier_d};
		end
	end

	assign result = result_q;

endmodule

// ----- hdl/ir_pulse_capture_replay_core.sv -----
// ir_pulse_capture_replay_core: top level of the ir pulse capture/replay block.
// Instantiates irpcr_ctrl and irpcr_datapath. Depends on irpcr_pkg.
`timescale 1ns / 1ps

// Each request on the slave stream (tuser = kind, tdata = duration) gives exactly
// one result on the master stream. A request is first accepted, with the pulse
// store read at the replay index, and then executed: state is updated, the
// store written and the result register loaded. One request is worked on at a time,
// the next is accepted as soon as the previous result is taken or is being taken.
// The 256-entry store reads as all zero right after reset; no clearing pass
// is needed. gap_threshold is written through cfg_valid/cfg_data, always ready,
// and should only be written while no request is in flight.
module ir_pulse_capture_replay_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// duration [31:0]
	input  logic [irpcr_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type [1:0]
	input  logic [irpcr_pkg::KIND_W-1:0]        s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// carrier_on [0], timer_load [1], timer_period [17:2], replay_active [18],
	// status [19], zero [23:20]
	output logic [irpcr_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	// gap_threshold [31:0]
	input  logic [irpcr_pkg::THR_W-1:0]         cfg_data
);

	irpcr_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	irpcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	irpcr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_type  (s_tuser),
		.duration  (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_wdata (cfg_data),
		.result    (m_tdata)
	);

endmodule

// ----- hdl/irpcr_checker.sv -----
// irpcr_checker: port-level assertions for ir_pulse_capture_replay_core,
// attached by a bind at the end of this file. Depends on irpcr_pkg.
`timescale 1ns / 1ps

module irpcr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [irpcr_pkg::OUT_DATA_W-1:0]    m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time: no accept while the request executes, then its result shows
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 m_tvalid)
		else $error("request not followed by its result");

	// period is zero unless the timer is loaded
	a_period_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[17:2] == '0)
		else $error("period without timer load");

	// carrier and timer loads only happen during a replay
	a_carrier_replay: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[0] || m_tdata[1]) |-> m_tdata[18])
		else $error("carrier or load outside replay");

endmodule

bind ir_pulse_capture_replay_core irpcr_checker u_irpcr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- bench/tb_ir_pulse_capture_replay_core.sv -----
// tb_ir_pulse_capture_replay_core: self-checking bench for the ir pulse capture/replay
// core, a class-based predictor checks every result on the master stream.
// Depends on irpcr_pkg and ir_pulse_capture_replay_core.
`timescale 1ns / 1ps

module tb_ir_pulse_capture_replay_core;
	import irpcr_pkg::*;

	// result layout on m_tdata, lowest bit last
	typedef struct packed {
		logic [3:0]          pad;
		logic                status;
		logic                replay_active;
		logic [PERIOD_W-1:0] timer_period;
		logic                timer_load;
		logic                carrier_on;
	} replay_result_t;

	class replay_tracker;
		bit [PERIOD_W-1:0] pulse_store [STORE_DEPTH];
		bit [CNT_W-1:0]    write_count;
		bit [CNT_W-1:0]    replay_index;
		bit                replaying;
		bit                carrier;
		bit                overflow;
		bit [THR_W-1:0]    gap_threshold;
		replay_result_t    expected_q[$];
		int unsigned       errors;

		function new();
			foreach (pulse_store[i]) pulse_store[i] = '0;
			gap_threshold = GAP_THRESHOLD_RST;
		endfunction

		function bit [PERIOD_W-1:0] entry_at(bit [CNT_W-1:0] idx);
			return (idx < STORE_DEPTH) ? pulse_store[idx] : '0;
		endfunction

		// returns 0 for a capture while replaying or overflowed, which changes nothing
		function bit note_request(logic [KIND_W-1:0] kind, logic [DUR_W-1:0] dur);
			replay_result_t r;
			bit [PERIOD_W-1:0] entry;
			bit took;
			r = '0;
			took = 1'b1;
			case (kind)
				REQ_CAPTURE: begin
					if (replaying || overflow) begin
						took = 1'b0;
					end else begin
						if (dur > gap_threshold) write_count = '0;
						if (write_count < STORE_DEPTH) begin
							pulse_store[write_count] = dur[PERIOD_W-1:0];
							// terminator, except behind the last entry
							if (write_count + 1 < STORE_DEPTH)
								pulse_store[write_count + 1] = '0;
							write_count++;
						end else begin
							overflow = 1'b1;
						end
					end
				end
				REQ_START: begin
					replay_index = CNT_W'(1);
					entry = entry_at(replay_index);
					if (entry != 0) begin
						replaying = 1'b1;
						carrier = 1'b1;
						r.timer_load = 1'b1;
						r.timer_period = entry;
						replay_index++;
					end else begin
						replaying = 1'b0;
						carrier = 1'b0;
					end
				end
				REQ_EXPIRY: begin
					entry = entry_at(replay_index);
					if (replaying && replay_index < STORE_DEPTH && entry != 0) begin
						carrier = !carrier;
						r.timer_load = 1'b1;
						r.timer_period = entry;
						replay_index++;
					end else begin
						carrier = 1'b0;
						replaying = 1'b0;
					end
				end
				default: begin
					overflow = 1'b0;
				end
			endcase
			r.carrier_on = carrier;
			r.replay_active = replaying;
			r.status = overflow;
			expected_q.push_back(r);
			return took;
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			replay_result_t want;
			replay_result_t got;
			got = data;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, data);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			field_check("carrier_on", 32'(want.carrier_on), 32'(got.carrier_on));
			field_check("timer_load", 32'(want.timer_load), 32'(got.timer_load));
			field_check("timer_period", 32'(want.timer_period), 32'(got.timer_period));
			field_check("replay_active", 32'(want.replay_active), 32'(got.replay_active));
			field_check("status", 32'(want.status), 32'(got.status));
			field_check("pad", 32'(want.pad), 32'(got.pad));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [KIND_W-1:0]     s_tuser = REQ_CAPTURE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [THR_W-1:0]      cfg_data = '0;

	replay_tracker sb = new();
	bit                    no_idle = 1'b0;
	int unsigned           live_items = 0;

	ir_pulse_capture_replay_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99, 0) < 7);
	endfunction

	always @(posedge clk) begin
		m_tready <= !idle_now();
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	task automatic send_request(logic [KIND_W-1:0] kind, logic [DUR_W-1:0] dur);
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= dur;
		do @(posedge clk); while (!s_tready);
		if (sb.note_request(kind, dur)) live_items++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.gap_threshold = value;
	endtask

	// pulse lengths that stay within the current recording
	function automatic logic [DUR_W-1:0] pulse_duration(logic [THR_W-1:0] thr);
		if (thr == 0) return '0;
		if (thr > 2000 && $urandom_range(1, 0)) return $urandom_range(2000, 1);
		return $urandom_range(thr, 1);
	endfunction

	// record a short burst, then play it back with some disturbance
	task automatic run_sequence();
		logic [THR_W-1:0] thr;
		int n;
		thr = sb.gap_threshold;
		if ($urandom_range(2, 0) == 0) send_request(REQ_CLEAR, $urandom);
		if (thr != '1) send_request(REQ_CAPTURE, $urandom_range(32'hFFFF_FFFF, thr + 1));
		n = $urandom_range(12, 1);
		repeat (n) begin
			if ($urandom_range(9, 0) == 0)
				send_request(KIND_W'($urandom_range(3, 0)), $urandom);
			send_request(REQ_CAPTURE, pulse_duration(thr));
		end
		send_request(REQ_START, $urandom);
		repeat (n + $urandom_range(2, 0)) begin
			case ($urandom_range(15, 0))
				0: send_request(REQ_START, $urandom);
				1: send_request(REQ_CAPTURE, pulse_duration(thr));
				default: ;
			endcase
			send_request(REQ_EXPIRY, $urandom);
		end
	endtask

	// fill every entry, overflow, then walk the replay off the end of the store
	task automatic run_full_store();
		send_request(REQ_CLEAR, $urandom);
		send_request(REQ_CAPTURE, $urandom_range(32'hFFFF_FFFF, sb.gap_threshold + 1));
		repeat (STORE_DEPTH - 1) send_request(REQ_CAPTURE, $urandom_range(65535, 1));
		repeat (2) send_request(REQ_CAPTURE, $urandom_range(65535, 1));
		send_request(REQ_START, $urandom);
		repeat (STORE_DEPTH) send_request(REQ_EXPIRY, $urandom);
		send_request(REQ_CLEAR, $urandom);
	endtask

	initial begin
		logic [THR_W-1:0] phase_thr [5];
		int unsigned target;
		phase_thr[0] = '0;
		phase_thr[1] = '1;
		phase_thr[2] = $urandom;
		phase_thr[3] = GAP_THRESHOLD_RST;
		phase_thr[4] = $urandom_range(300, 20);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset threshold
		send_request(REQ_EXPIRY, '0);
		send_request(REQ_START, '0);
		send_request(REQ_CLEAR, '1);
		send_request(REQ_CAPTURE, 32'h0001_0000);
		send_request(REQ_CAPTURE, 32'h0000_FFFF);
		send_request(REQ_CAPTURE, 32'd1);
		send_request(REQ_CAPTURE, 32'd0);
		send_request(REQ_START, '0);
		send_request(REQ_CAPTURE, 32'd5);
		send_request(REQ_START, '1);
		send_request(REQ_EXPIRY, '0);
		send_request(REQ_EXPIRY, '1);
		send_request(REQ_EXPIRY, '0);
		send_request(REQ_CAPTURE, 32'hFFFF_FFFF);
		send_request(REQ_CAPTURE, 32'h0000_AAAA);
		send_request(REQ_CAPTURE, 32'h0000_5555);
		send_request(REQ_START, '0);
		repeat (3) send_request(REQ_EXPIRY, '0);
		send_request(REQ_CLEAR, '0);

		for (int p = 0; p < 5; p++) begin
			wait_drained();
			write_threshold(phase_thr[p]);
			no_idle = (p == 1);
			if (p == 3) run_full_store();
			target = live_items + 30;
			while (live_items < target) run_sequence();
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			if (sb.expected_q.size() != 0)
				$display("%0t: %0d results missing", $time, sb.expected_q.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
